// ===== hdl/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment intersection test package
// Shared types and fixed field widths for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int FIELD_W    = 16;
  localparam int NUM_FIELDS = 8;
  localparam int IN_DATA_W  = FIELD_W * NUM_FIELDS;
  localparam int OUT_DATA_W = 8;

  // Load enables of the three pipeline registers inside the orientation unit.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Endpoint and identity tests that travel beside the orientation signs.
  typedef struct packed {
    logic in_a;
    logic in_b;
    logic in_c;
    logic in_d;
    logic ident;
  } flags_t;

endpackage

// ===== hdl/sit_orient.sv =====
// ----------------------------------------------------------------------------
// Orientation unit
// Three-stage pipelined sign of the cross product (q - p) x (r - p).
// ----------------------------------------------------------------------------
module sit_orient #(
  parameter int W = 16
) (
  input  logic                clk,
  input  sit_pkg::stage_en_t  en,
  input  logic signed [W-1:0] px,
  input  logic signed [W-1:0] py,
  input  logic signed [W-1:0] qx,
  input  logic signed [W-1:0] qy,
  input  logic signed [W-1:0] rx,
  input  logic signed [W-1:0] ry,
  output logic                gt,
  output logic                lt
);

  localparam int DW = W + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] qpx_r, qpy_r, rpx_r, rpy_r;
  logic signed [DW-1:0] qpx_nxt, qpy_nxt, rpx_nxt, rpy_nxt;
  logic signed [PW-1:0] lhs_r, rhs_r, lhs_nxt, rhs_nxt;
  logic                 gt_r, lt_r;

  assign qpx_nxt = DW'(qx) - DW'(px);
  assign qpy_nxt = DW'(qy) - DW'(py);
  assign rpx_nxt = DW'(rx) - DW'(px);
  assign rpy_nxt = DW'(ry) - DW'(py);

  assign lhs_nxt = PW'(qpx_r) * PW'(rpy_r);
  assign rhs_nxt = PW'(qpy_r) * PW'(rpx_r);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      qpx_r <= qpx_nxt;
      qpy_r <= qpy_nxt;
      rpx_r <= rpx_nxt;
      rpy_r <= rpy_nxt;
    end
    if (en.s2) begin
      lhs_r <= lhs_nxt;
      rhs_r <= rhs_nxt;
    end
    if (en.s3) begin
      gt_r <= lhs_r > rhs_r;
      lt_r <= lhs_r < rhs_r;
    end
  end

  assign gt = gt_r;
  assign lt = lt_r;

endmodule

// ===== hdl/segment_intersection_test_top.sv =====
// ----------------------------------------------------------------------------
// Segment intersection test
// Decides whether two 2-D integer segments AB and CD intersect.
//
//   Channel  Direction  Payload
//   in_      slave      tdata: ax, ay, bx, by, cx, cy, dx, dy (16 bits each)
//   out_     master     tdata: intersects (bit 0), zero padding to 8 bits
//
// One word is accepted per cycle while the output is not stalled; the result is
// offered through four registers: differences, products, sign compare, then
// the output register.
// Each stage holds its word while the next one is full and stalled, and a
// bubble in any stage is filled, so a stall loses nothing.
// Reset clears the valid bits of all stages.
// ----------------------------------------------------------------------------
module segment_intersection_test_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // ax, ay, bx, by, cx, cy, dx, dy from the lowest bit up, 16 bits each.
  input  logic [sit_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // intersects, then seven zero bits.
  output logic [sit_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int CW    = COORD_BITS;
  localparam int FW    = sit_pkg::FIELD_W;
  localparam int EXT_W = (CW > FW) ? CW : FW;

  logic signed [CW-1:0] crd [sit_pkg::NUM_FIELDS];
  logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;

  logic v1_r, v2_r, v3_r, out_valid_r;
  logic ld1, ld2, ld3, ld_out;
  sit_pkg::stage_en_t en;
  sit_pkg::flags_t    flags_nxt, f1_r, f2_r, f3_r;
  logic gt1, lt1, gt2, lt2, gt3, lt3, gt4, lt4;
  logic hit_nxt, hit_r;

  function automatic logic between(input logic signed [CW-1:0] e0,
                                   input logic signed [CW-1:0] e1,
                                   input logic signed [CW-1:0] v);
    between = (e0 < v && v < e1) || (e1 < v && v < e0);
  endfunction

  always_comb begin
    for (int i = 0; i < sit_pkg::NUM_FIELDS; i++) begin
      crd[i] = CW'(EXT_W'(in_tdata[i*FW +: FW]));
    end
  end

  assign ax = crd[0];
  assign ay = crd[1];
  assign bx = crd[2];
  assign by = crd[3];
  assign cx = crd[4];
  assign cy = crd[5];
  assign dx = crd[6];
  assign dy = crd[7];

  always_comb begin
    flags_nxt.in_a  = between(cx, dx, ax) || between(cy, dy, ay);
    flags_nxt.in_b  = between(cx, dx, bx) || between(cy, dy, by);
    flags_nxt.in_c  = between(ax, bx, cx) || between(ay, by, cy);
    flags_nxt.in_d  = between(ax, bx, dx) || between(ay, by, dy);
    flags_nxt.ident = (ax == cx && ay == cy && bx == dx && by == dy) ||
                      (ax == dx && ay == dy && bx == cx && by == cy);
  end

  assign ld_out    = !out_valid_r || out_tready;
  assign ld3       = !v3_r || ld_out;
  assign ld2       = !v2_r || ld3;
  assign ld1       = !v1_r || ld2;
  assign in_tready = ld1;

  assign en.s1 = ld1;
  assign en.s2 = ld2;
  assign en.s3 = ld3;

  sit_orient #(.W(CW)) u_orient_a (
    .clk(clk), .en(en), .px(cx), .py(cy), .qx(dx), .qy(dy), .rx(ax), .ry(ay),
    .gt(gt1), .lt(lt1)
  );

  sit_orient #(.W(CW)) u_orient_b (
    .clk(clk), .en(en), .px(cx), .py(cy), .qx(dx), .qy(dy), .rx(bx), .ry(by),
    .gt(gt2), .lt(lt2)
  );

  sit_orient #(.W(CW)) u_orient_c (
    .clk(clk), .en(en), .px(ax), .py(ay), .qx(bx), .qy(by), .rx(cx), .ry(cy),
    .gt(gt3), .lt(lt3)
  );

  sit_orient #(.W(CW)) u_orient_d (
    .clk(clk), .en(en), .px(ax), .py(ay), .qx(bx), .qy(by), .rx(dx), .ry(dy),
    .gt(gt4), .lt(lt4)
  );

  assign hit_nxt = (((gt1 && lt2) || (lt1 && gt2)) && ((gt3 && lt4) || (lt3 && gt4)))
                || (!gt1 && !lt1 && f3_r.in_a)
                || (!gt2 && !lt2 && f3_r.in_b)
                || (!gt3 && !lt3 && f3_r.in_c)
                || (!gt4 && !lt4 && f3_r.in_d)
                || f3_r.ident;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= in_tvalid;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
      if (ld3) begin
        v3_r <= v2_r;
      end
      if (ld_out) begin
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      f1_r <= flags_nxt;
    end
    if (ld2) begin
      f2_r <= f1_r;
    end
    if (ld3) begin
      f3_r <= f2_r;
    end
    if (ld_out) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(sit_pkg::OUT_DATA_W - 1)'(0), hit_r};

endmodule

// ===== hdl/sit_checker.sv =====
// ----------------------------------------------------------------------------
// Segment intersection test checker
// Port-level assertions on the handshakes and reset of the top level.
// ----------------------------------------------------------------------------
module sit_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [sit_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A word that is waiting on the output stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // Its data does not change while it waits.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output word changed while stalled");

  // With nothing on the output, the pipeline always has room for a new word.
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input refused while output is empty");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind segment_intersection_test_top sit_checker u_sit_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
